// ===== sv/cmb_pkg.sv =====
// ----------------------------------------------------------------------------
// cmb_pkg: shared types and constants of the C comment blanker
// Byte codes, the one-hot scanner mode and the result item formats.
// ----------------------------------------------------------------------------
package cmb_pkg;

    // Byte codes the scanner reacts to
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FFEED     = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Result count field values
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Scanner mode, one-hot
    typedef enum logic [7:0] {
        MODE_CODE       = 8'b0000_0001,
        MODE_SLASH      = 8'b0000_0010,
        MODE_SQUOTE     = 8'b0000_0100,
        MODE_DQUOTE     = 8'b0000_1000,
        MODE_BLOCK      = 8'b0001_0000,
        MODE_BLOCK_STAR = 8'b0010_0000,
        MODE_LINE       = 8'b0100_0000,
        MODE_LINE_BS    = 8'b1000_0000
    } t_mode;

    // One output item
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_item;

    // Results of one input item, item0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_item      item0;
        t_item      item1;
    } t_scan_res;

    // Output queue status towards the top level
    typedef struct packed {
        logic valid;
        logic room;
    } t_q_stat;

endpackage

// ===== sv/cmb_in_stage.sv =====
// ----------------------------------------------------------------------------
// cmb_in_stage: input register of the C comment blanker
// Holds one accepted source byte until the scanner takes it.
// ----------------------------------------------------------------------------
module cmb_in_stage
    import cmb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_char,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;

    // Accept when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;

    // Control: track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload: load on accept
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// ===== sv/cmb_scan.sv =====
// ----------------------------------------------------------------------------
// cmb_scan: scanner mode register and per-byte decode
// Works out zero, one or two output bytes and the next mode for one byte.
// ----------------------------------------------------------------------------
module cmb_scan
    import cmb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_scan_res  o_res,
    output t_mode      o_mode
);

    t_mode      r_mode;
    t_mode      n_mode;
    logic [1:0] cnt;
    logic [7:0] e0;
    logic [7:0] e1;

    // Code-mode handling of a byte that is not a slash
    function automatic t_mode code_next(input logic [7:0] c);
        t_mode m;
        m = MODE_CODE;
        if (c == CH_SQUOTE) begin
            m = MODE_SQUOTE;
        end else if (c == CH_DQUOTE) begin
            m = MODE_DQUOTE;
        end
        return m;
    endfunction

    // Decode the byte against the current mode
    always_comb begin
        n_mode = r_mode;
        cnt    = CNT_NONE;
        e0     = CH_SPACE;
        e1     = CH_SPACE;
        case (r_mode)
            MODE_SLASH: begin
                cnt = CNT_TWO;
                if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end else if (i_char == CH_SLASH) begin
                    n_mode = MODE_LINE;
                end else begin
                    // release the held slash, then treat the byte as code
                    e0     = CH_SLASH;
                    e1     = i_char;
                    n_mode = code_next(i_char);
                end
            end
            MODE_SQUOTE: begin
                cnt = CNT_ONE;
                e0  = i_char;
                if (i_char == CH_SQUOTE) begin
                    n_mode = MODE_CODE;
                end
            end
            MODE_DQUOTE: begin
                cnt = CNT_ONE;
                e0  = i_char;
                if (i_char == CH_DQUOTE) begin
                    n_mode = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                cnt = CNT_ONE;
                if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                cnt = CNT_ONE;
                if (i_char == CH_SLASH) begin
                    n_mode = MODE_CODE;
                end else if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK_STAR;
                end else begin
                    n_mode = MODE_BLOCK;
                end
            end
            MODE_LINE: begin
                cnt = CNT_ONE;
                if (i_char == CH_NEWLINE) begin
                    e0     = CH_NEWLINE;
                    n_mode = MODE_CODE;
                end else if (i_char == CH_BACKSLASH) begin
                    n_mode = MODE_LINE_BS;
                end
            end
            MODE_LINE_BS: begin
                cnt = CNT_ONE;
                if (i_char == CH_NEWLINE) begin
                    e0     = CH_NEWLINE;
                    n_mode = MODE_LINE;
                end else if (!(i_char inside {CH_SPACE, CH_TAB, CH_VTAB,
                                              CH_FFEED, CH_CR})) begin
                    n_mode = MODE_LINE;
                end
            end
            default: begin
                // code mode: hold a slash unless the text ends here
                if (i_char == CH_SLASH) begin
                    cnt    = i_last ? CNT_ONE : CNT_NONE;
                    e0     = CH_SLASH;
                    n_mode = MODE_SLASH;
                end else begin
                    cnt    = CNT_ONE;
                    e0     = i_char;
                    n_mode = code_next(i_char);
                end
            end
        endcase
    end

    // Mark the final result of a closing byte
    always_comb begin
        o_res.cnt        = cnt;
        o_res.item0.ch   = e0;
        o_res.item0.last = i_last && (cnt == CNT_ONE);
        o_res.item1.ch   = e1;
        o_res.item1.last = i_last && (cnt == CNT_TWO);
    end

    // Advance the mode; end of text returns to code mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CODE;
        end else if (i_fire) begin
            r_mode <= i_last ? MODE_CODE : n_mode;
        end
    end

    assign o_mode = r_mode;

endmodule

// ===== sv/cmb_out_q.sv =====
// ----------------------------------------------------------------------------
// cmb_out_q: three-entry output queue
// Takes up to two items per cycle, hands out one; head is always entry 0.
// ----------------------------------------------------------------------------
module cmb_out_q
    import cmb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_scan_res i_res,
    input  logic      i_ready,
    output t_q_stat   o_stat,
    output t_item     o_item
);

    localparam int QDEPTH = 3;

    t_item      r_q [QDEPTH];
    t_item      n_q [QDEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;
    logic [1:0] base;
    logic [1:0] add;

    assign pop  = (r_cnt != 2'd0) && i_ready;
    assign base = r_cnt - {1'b0, pop};
    assign add  = i_push ? i_res.cnt : CNT_NONE;

    // Shift on pop, then append new items behind the survivors
    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            n_q[i] = pop ? r_q[i + 1] : r_q[i];
        end
        n_q[QDEPTH - 1] = r_q[QDEPTH - 1];
        for (int i = 0; i < QDEPTH; i++) begin
            if (add != CNT_NONE && 2'(i) == base) begin
                n_q[i] = i_res.item0;
            end
            if (add == CNT_TWO && 2'(i) == base + 2'd1) begin
                n_q[i] = i_res.item1;
            end
        end
        n_cnt = base + add;
    end

    // Control: fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Payload: entries
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // Room for a worst-case pair after this cycle's pop
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.room  = (base <= 2'd1);
    assign o_item       = r_q[0];

endmodule

// ===== sv/c_comment_blanker_core.sv =====
// ----------------------------------------------------------------------------
// c_comment_blanker_core: streaming C comment blanker
// Passes C source bytewise, comments to spaces, line-comment newlines kept.
// ----------------------------------------------------------------------------
// The block accepts one source byte per cycle and keeps the text length: each
// byte yields one output byte, except that a slash in code is held until the
// next byte shows whether a comment opens, so that byte then yields two (two
// spaces, or the slash and the byte). The held slash yields nothing, so the
// pair still averages one byte per cycle and the input never waits while the
// receiver takes a byte every cycle; the extra byte sits in a three-entry
// output queue, which delays the bytes behind it until the output next runs
// dry. An accepted byte passes the input register, then the queue head, on
// its way out. The input stalls only when the receiver holds off and the
// queue cannot take a worst-case pair. tlast marks the last output byte of a
// text, and the scanner restarts in code mode after every byte with tlast
// set; a slash that ends a text is sent at once.
// ----------------------------------------------------------------------------
module c_comment_blanker_core
    import cmb_pkg::*;
#(
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] char_in
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] char_out
    output logic       o_m_axis_tlast
);

    logic       in_valid;
    logic [7:0] in_char;
    logic       in_last;
    logic       take;
    t_scan_res  res;
    t_mode      mode;
    t_q_stat    q_stat;
    t_item      q_item;

    // Hold the incoming byte
    cmb_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_char  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_take  (take),
        .o_valid (in_valid),
        .o_char  (in_char),
        .o_last  (in_last)
    );

    // Scan a held byte once the queue can take two items
    assign take = in_valid && q_stat.room;

    cmb_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (take),
        .i_char  (in_char),
        .i_last  (in_last),
        .o_res   (res),
        .o_mode  (mode)
    );

    cmb_out_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_res   (res),
        .i_ready (i_m_axis_tready),
        .o_stat  (q_stat),
        .o_item  (q_item)
    );

    assign o_m_axis_tvalid = q_stat.valid;
    assign o_m_axis_tdata  = q_item.ch;
    assign o_m_axis_tlast  = q_item.last;

    // A byte that ends a text always produces output
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && in_last) |-> (res.cnt != CNT_NONE))
        else $error("closing byte produced no output");

    // The scanner is back in code mode after the end of a text
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && in_last) |=> (mode == MODE_CODE))
        else $error("scanner mode not cleared after end of text");

    // No more than two items per byte
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (res.cnt != 2'd3))
        else $error("invalid result count");

    // A byte held back by the queue stays held
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !take) |=> (in_valid && $stable(in_char) && $stable(in_last)))
        else $error("held input byte lost");

endmodule

// ===== sim/cmb_blank_checker.sv =====
// ----------------------------------------------------------------------------
// cmb_blank_checker: scoreboard for the C comment blanker
// Tracks the scanner mode from accepted input items, queues the output bytes
// they should produce and compares every accepted output item in order.
// ----------------------------------------------------------------------------
module cmb_blank_checker
    import cmb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_src_tvalid,
    input  logic       i_src_tready,
    input  logic [7:0] i_src_tdata,   // [7:0] char_in
    input  logic       i_src_tlast,
    input  logic       i_txt_tvalid,
    input  logic       i_txt_tready,
    input  logic [7:0] i_txt_tdata,   // [7:0] char_out
    input  logic       i_txt_tlast,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked
);

    localparam int MAX_PRINTED = 40;

    t_mode scan_mode;
    t_item clean_bytes_q[$];
    int    error_cnt;
    int    byte_cnt;

    // Mode entered by a byte handled as code
    function automatic t_mode code_mode_after(input logic [7:0] ch);
        if (ch == CH_SQUOTE)
            return MODE_SQUOTE;
        if (ch == CH_DQUOTE)
            return MODE_DQUOTE;
        return MODE_CODE;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_NEWLINE ||
               ch == CH_VTAB || ch == CH_FFEED || ch == CH_CR;
    endfunction

    // Advance the scanner by one source byte and queue the bytes it releases
    function automatic void blank_source_byte(input logic [7:0] ch, input logic eot);
        logic [7:0] out_ch [2];
        int         n;
        t_mode      nxt;
        t_item      it;
        n   = 0;
        nxt = scan_mode;
        case (scan_mode)
            MODE_SLASH: begin
                n = 2;
                if (ch == CH_STAR || ch == CH_SLASH) begin
                    out_ch[0] = CH_SPACE;
                    out_ch[1] = CH_SPACE;
                    nxt = (ch == CH_STAR) ? MODE_BLOCK : MODE_LINE;
                end else begin
                    out_ch[0] = CH_SLASH;
                    out_ch[1] = ch;
                    nxt = code_mode_after(ch);
                end
            end
            MODE_SQUOTE: begin
                out_ch[n++] = ch;
                if (ch == CH_SQUOTE)
                    nxt = MODE_CODE;
            end
            MODE_DQUOTE: begin
                out_ch[n++] = ch;
                if (ch == CH_DQUOTE)
                    nxt = MODE_CODE;
            end
            MODE_BLOCK: begin
                out_ch[n++] = CH_SPACE;
                if (ch == CH_STAR)
                    nxt = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                out_ch[n++] = CH_SPACE;
                if (ch == CH_SLASH)
                    nxt = MODE_CODE;
                else if (ch != CH_STAR)
                    nxt = MODE_BLOCK;
            end
            MODE_LINE: begin
                out_ch[n++] = (ch == CH_NEWLINE) ? CH_NEWLINE : CH_SPACE;
                if (ch == CH_NEWLINE)
                    nxt = MODE_CODE;
                else if (ch == CH_BACKSLASH)
                    nxt = MODE_LINE_BS;
            end
            MODE_LINE_BS: begin
                out_ch[n++] = (ch == CH_NEWLINE) ? CH_NEWLINE : CH_SPACE;
                if (ch == CH_NEWLINE || !is_blank(ch))
                    nxt = MODE_LINE;
            end
            default: begin
                // Hold a slash in code unless the text ends on it
                if (ch == CH_SLASH) begin
                    if (eot)
                        out_ch[n++] = CH_SLASH;
                    nxt = MODE_SLASH;
                end else begin
                    out_ch[n++] = ch;
                    nxt = code_mode_after(ch);
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            it.ch   = out_ch[k];
            it.last = eot && (k == n - 1);
            clean_bytes_q.push_back(it);
        end
        scan_mode = eot ? MODE_CODE : nxt;
    endfunction

    task automatic report_mismatch(input string msg);
        error_cnt++;
        if (error_cnt <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one output item with the oldest queued byte
    task automatic check_clean_byte(input logic [7:0] ch, input logic eot);
        t_item want;
        if (clean_bytes_q.size() == 0) begin
            report_mismatch($sformatf("unexpected output byte 0x%02h last=%0b", ch, eot));
        end else begin
            want = clean_bytes_q.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("output byte %0d: char 0x%02h, expected 0x%02h",
                                          byte_cnt, ch, want.ch));
            if (eot !== want.last)
                report_mismatch($sformatf("output byte %0d: last %0b, expected %0b",
                                          byte_cnt, eot, want.last));
            byte_cnt++;
        end
    endtask

    // Watch both channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_mode = MODE_CODE;
            clean_bytes_q.delete();
        end else begin
            if (i_src_tvalid && i_src_tready)
                blank_source_byte(i_src_tdata, i_src_tlast);
            if (i_txt_tvalid && i_txt_tready)
                check_clean_byte(i_txt_tdata, i_txt_tlast);
        end
        o_pending <= clean_bytes_q.size();
        o_errors  <= error_cnt;
        o_checked <= byte_cnt;
    end

endmodule

// ===== sim/tb_c_comment_blanker_core.sv =====
// ----------------------------------------------------------------------------
// tb_c_comment_blanker_core: testbench of the C comment blanker
// Feeds short C-like texts (comments, quotes, stray slashes, random bytes)
// through the block under four idling phases and receiver hold-offs, and
// leaves all checking to the scoreboard instance beside the block.
// ----------------------------------------------------------------------------
module tb_c_comment_blanker_core;
    import cmb_pkg::*;

    localparam int N_ITEMS         = 1900;
    localparam int N_PHASES        = 4;
    localparam int PHASE_ITEMS     = (N_ITEMS - 25) / N_PHASES;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;  // [7:0] char_in
    logic       i_s_axis_tlast  = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;           // [7:0] char_out
    logic       o_m_axis_tlast;

    int fail_cnt;
    int pending_cnt;
    int checked_cnt;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_cnt      = 0;
    int sent_cnt       = 0;
    int text_cnt       = 0;

    logic [7:0] text_q[$];

    always #4 i_clk = ~i_clk;

    c_comment_blanker_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    cmb_blank_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_src_tvalid (i_s_axis_tvalid),
        .i_src_tready (o_s_axis_tready),
        .i_src_tdata  (i_s_axis_tdata),
        .i_src_tlast  (i_s_axis_tlast),
        .i_txt_tvalid (o_m_axis_tvalid),
        .i_txt_tready (i_m_axis_tready),
        .i_txt_tdata  (o_m_axis_tdata),
        .i_txt_tlast  (o_m_axis_tlast),
        .o_errors     (fail_cnt),
        .o_pending    (pending_cnt),
        .o_checked    (checked_cnt)
    );

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen       <= hold_reqs;
            hold_left       <= HOLD_OFF_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d output bytes still awaited",
                     cycle_cnt, pending_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Code byte, printable or a newline, that neither opens a comment nor a quote
    function automatic logic [7:0] code_byte();
        logic [7:0] c;
        if ($urandom_range(9) == 0)
            return CH_NEWLINE;
        do
            c = 8'($urandom_range(126, 32));
        while (c == CH_SLASH || c == CH_SQUOTE || c == CH_DQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VTAB;
            3:       return CH_FFEED;
            default: return CH_CR;
        endcase
    endfunction

    // Byte for a comment body, biased towards the bytes the scanner reacts to
    function automatic logic [7:0] comment_byte();
        case ($urandom_range(9))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return CH_BACKSLASH;
            3:       return blank_byte();
            4:       return 8'($urandom_range(255));
            default: return code_byte();
        endcase
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // Append one random piece of C-like text
    function automatic void add_fragment();
        int         len;
        logic [7:0] q;
        len = $urandom_range(8);
        case ($urandom_range(9))
            0, 1, 2: begin
                for (int i = 0; i <= len; i++)
                    text_q.push_back(code_byte());
            end
            3, 4: begin
                // block comment, closed by a run of stars and a slash
                push_str("/*");
                for (int i = 0; i < len; i++)
                    text_q.push_back($urandom_range(3) == 0 ? CH_NEWLINE : comment_byte());
                repeat ($urandom_range(3, 1))
                    text_q.push_back(CH_STAR);
                text_q.push_back(CH_SLASH);
            end
            5: begin
                // line comment, possibly continued over a backslash
                push_str("//");
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(4) == 0) begin
                        text_q.push_back(CH_BACKSLASH);
                        repeat ($urandom_range(2))
                            text_q.push_back(blank_byte());
                        if ($urandom_range(1))
                            text_q.push_back(CH_NEWLINE);
                    end else begin
                        text_q.push_back(comment_byte());
                    end
                end
                text_q.push_back(CH_NEWLINE);
            end
            6: begin
                q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                text_q.push_back(q);
                for (int i = 0; i < len; i++)
                    text_q.push_back($urandom_range(1) ? comment_byte() : code_byte());
                text_q.push_back(q);
            end
            7: begin
                // slash followed by a quote or by a code byte, which can be a star that opens a comment
                text_q.push_back(CH_SLASH);
                if ($urandom_range(2) == 0) begin
                    q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                    text_q.push_back(q);
                    text_q.push_back(code_byte());
                    text_q.push_back(q);
                end else begin
                    text_q.push_back(code_byte());
                end
            end
            8: begin
                for (int i = 0; i <= len % 4; i++)
                    text_q.push_back(8'($urandom_range(255)));
            end
            default: begin
                // opener left open: a lone slash, a comment or a quote
                case ($urandom_range(3))
                    0:       text_q.push_back(CH_SLASH);
                    1:       push_str("/*");
                    2:       push_str("//");
                    default: text_q.push_back(CH_DQUOTE);
                endcase
                for (int i = 0; i < len % 3; i++)
                    text_q.push_back(comment_byte());
            end
        endcase
    endfunction

    // Offer one item and wait for its handshake
    task automatic send_item(input logic [7:0] ch, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= eot;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        sent_cnt++;
    endtask

    // Send the built text, tlast on its final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_item(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        text_cnt++;
    endtask

    // Stop offering until every queued output byte has come out
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_cnt != 0);
    endtask

    initial begin
        int phase_end;
        int n_frags;
        logic hold_asked;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme bytes, block comment with newline and star run
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        push_str("/*a*\n**/");
        send_text();
        // line comment continued over backslash and blank
        push_str("//\\ \n\n");
        send_text();
        // quote right after a slash, comment opener inside a string
        push_str("/'a'\"/*\"");
        send_text();
        // slash that ends the text
        push_str("/");
        send_text();
        wait_drained();

        // Random texts over the idling phases
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 70;
                end
                default: begin
                    send_idle_pct = 16;
                    recv_stall_pct <= 16;
                end
            endcase
            phase_end  = sent_cnt + PHASE_ITEMS;
            hold_asked = 1'b0;
            while (sent_cnt < phase_end) begin
                n_frags = ($urandom_range(9) == 0) ? 1 : $urandom_range(5, 1);
                repeat (n_frags)
                    add_fragment();
                send_text();
                // Long receiver hold-off while the sender keeps pushing
                if (phase % 2 == 0 && !hold_asked &&
                    sent_cnt >= phase_end - PHASE_ITEMS / 2) begin
                    hold_reqs  <= hold_reqs + 1;
                    hold_asked = 1'b1;
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d source bytes in %0d texts over %0d idling phases with hold-offs;",
                 sent_cnt, text_cnt, N_PHASES);
        $display("checked %0d cleaned bytes, %0d mismatches.", checked_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cmb_pkg.sv
sv/cmb_in_stage.sv
sv/cmb_scan.sv
sv/cmb_out_q.sv
sv/c_comment_blanker_core.sv
sim/cmb_blank_checker.sv
sim/tb_c_comment_blanker_core.sv
